// ===== rtl/npm_pkg.sv =====
package npm_pkg;

    localparam logic [31:0] P_MOD = 32'd998244353;
    localparam logic [63:0] P64 = 64'd998244353;
    localparam logic [31:0] GEN = 32'd3;
    localparam int MONT_LAT = 5;
    localparam int ADDR_W = 6;

    typedef enum logic [1:0] {OP_GS, OP_CT, OP_PW, OP_SC} op_t;

    typedef struct packed {
        logic              load;
        logic              rd;
        logic              pre;
        logic              wr_lo;
        logic              wr_hi;
        logic              emit;
        logic              emit_last;
        logic              sel_b;
        logic              zero0;
        logic              zero1;
        op_t               op;
        logic [ADDR_W-1:0] addr0;
        logic [ADDR_W-1:0] addr1;
        logic [4:0]        tw;
        logic [2:0]        lg;
    } cmd_t;

    typedef logic [31:0][29:0] tw_arr_t;
    typedef logic [7:0][29:0] sc_arr_t;

    function automatic logic [31:0] mulmod(logic [31:0] a, logic [31:0] b);
        logic [63:0] t;
        t = {32'd0, a} * {32'd0, b};
        return 32'(t % P64);
    endfunction

    function automatic logic [31:0] powmod(logic [31:0] b, logic [31:0] e);
        logic [31:0] r;
        logic [31:0] x;
        r = 32'd1;
        x = b;
        for (int i = 0; i < 32; i++) begin
            if (e[i])
                r = mulmod(r, x);
            x = mulmod(x, x);
        end
        return r;
    endfunction

    localparam logic [31:0] R_MOD = 32'((64'd1 << 32) % P64);

    function automatic logic [31:0] mont_np();
        logic [31:0] inv;
        inv = P_MOD;
        for (int i = 0; i < 5; i++)
            inv = inv * (32'd2 - P_MOD * inv);
        return 32'd0 - inv;
    endfunction

    localparam logic [31:0] NP = mont_np();

    // powers of the 64th root of unity, Montgomery form
    function automatic tw_arr_t make_tw(logic inv);
        tw_arr_t t;
        logic [31:0] root;
        logic [31:0] w;
        root = powmod(GEN, (P_MOD - 32'd1) >> 6);
        if (inv)
            root = powmod(root, P_MOD - 32'd2);
        w = 32'd1;
        for (int k = 0; k < 32; k++) begin
            t[k] = 30'(mulmod(w, R_MOD));
            w = mulmod(w, root);
        end
        return t;
    endfunction

    // 1/L * R^2: undoes the R^-1 left by the pointwise product
    function automatic sc_arr_t make_sc();
        sc_arr_t t;
        logic [31:0] linv;
        t = '0;
        for (int lg = 1; lg < 7; lg++) begin
            linv = powmod(32'd1 << lg, P_MOD - 32'd2);
            t[lg] = 30'(mulmod(mulmod(linv, R_MOD), R_MOD));
        end
        return t;
    endfunction

    localparam tw_arr_t TW_FWD = make_tw(1'b0);
    localparam tw_arr_t TW_INV = make_tw(1'b1);
    localparam sc_arr_t SC_TAB = make_sc();

    function automatic int max_pow2(int ts);
        int p;
        p = 2;
        for (int i = 0; i < 6; i++)
            if (p * 2 <= ts && p * 2 <= 64)
                p = p * 2;
        return p;
    endfunction

    function automatic logic [2:0] lg_of(logic [5:0] n);
        logic [2:0] r;
        r = 3'd1;
        for (int i = 1; i < 6; i++)
            if ((7'd1 << i) < {n, 1'b0})
                r = 3'(i + 1);
        return r;
    endfunction

endpackage

// ===== rtl/npm_mont.sv =====
module npm_mont
    import npm_pkg::*;
(
    input  logic        clk,
    input  logic [29:0] x,
    input  logic [29:0] y,
    output logic [29:0] r
);

    logic [59:0] t1_reg;
    logic [59:0] t2_reg;
    logic [59:0] t3_reg;
    logic [31:0] m2_reg;
    logic [61:0] mp3_reg;
    logic [30:0] s4_reg;
    logic [29:0] r5_reg;
    logic [62:0] sum;

    assign sum = {3'd0, t3_reg} + {1'b0, mp3_reg};

    always_ff @(posedge clk)
    begin
        t1_reg  <= {30'd0, x} * {30'd0, y};
        m2_reg  <= 32'(t1_reg[31:0] * NP);
        t2_reg  <= t1_reg;
        mp3_reg <= {30'd0, m2_reg} * {32'd0, P_MOD[29:0]};
        t3_reg  <= t2_reg;
        s4_reg  <= sum[62:32];
        r5_reg  <= (s4_reg >= 31'(P_MOD)) ? 30'(s4_reg - 31'(P_MOD)) : s4_reg[29:0];
    end

    assign r = r5_reg;

endmodule

// ===== rtl/npm_dp.sv =====
module npm_dp
    import npm_pkg::*;
#(
    parameter int DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    input  logic [29:0] a_coef,
    input  logic [29:0] b_coef,
    output logic [29:0] prod_coef,
    output logic        last_out,
    output logic        prod_valid
);

    localparam int AW = $clog2(DEPTH);

    logic [29:0] mem_a_reg [DEPTH];
    logic [29:0] mem_b_reg [DEPTH];
    logic [29:0] ra0_reg, ra1_reg, rb0_reg, rb1_reg;
    logic [29:0] mx_reg, my_reg, u_reg;
    logic [29:0] mx_next, my_next, u_next;
    logic [29:0] mres, x0, x1, lo_data, hi_data, wr_data;
    logic [29:0] red_a, red_b, wdata_a, wdata_b;
    logic [AW-1:0] a0, a1, waddr;
    logic we_a, we_b;
    logic emit_reg, emit_last_reg;

    function automatic logic [29:0] addm(logic [29:0] p, logic [29:0] q);
        logic [30:0] s;
        s = {1'b0, p} + {1'b0, q};
        return (s >= 31'(P_MOD)) ? 30'(s - 31'(P_MOD)) : s[29:0];
    endfunction

    function automatic logic [29:0] subm(logic [29:0] p, logic [29:0] q);
        logic [30:0] s;
        s = (p >= q) ? {1'b0, p} - {1'b0, q} : {1'b0, p} + 31'(P_MOD) - {1'b0, q};
        return s[29:0];
    endfunction

    assign a0 = cmd.addr0[AW-1:0];
    assign a1 = cmd.addr1[AW-1:0];
    assign x0 = cmd.sel_b ? rb0_reg : ra0_reg;
    assign x1 = cmd.sel_b ? rb1_reg : ra1_reg;

    // inputs are below 2^30 < 2p: one subtract
    assign red_a = (a_coef >= P_MOD[29:0]) ? a_coef - P_MOD[29:0] : a_coef;
    assign red_b = (b_coef >= P_MOD[29:0]) ? b_coef - P_MOD[29:0] : b_coef;

    npm_mont u_mont (
        .clk (clk),
        .x   (mx_reg),
        .y   (my_reg),
        .r   (mres)
    );

    always_comb
    begin
        mx_next = x0;
        my_next = TW_FWD[cmd.tw];
        u_next  = x0;
        lo_data = mres;
        hi_data = mres;
        case (cmd.op)
            OP_GS:
            begin
                mx_next = subm(x0, x1);
                u_next  = addm(x0, x1);
                lo_data = u_reg;
            end
            OP_CT:
            begin
                mx_next = x1;
                my_next = TW_INV[cmd.tw];
                lo_data = addm(u_reg, mres);
                hi_data = subm(u_reg, mres);
            end
            OP_PW:
            begin
                mx_next = ra0_reg;
                my_next = rb0_reg;
            end
            OP_SC:
            begin
                mx_next = ra0_reg;
                my_next = SC_TAB[cmd.lg];
            end
            default:
            begin
                mx_next = x0;
            end
        endcase
    end

    assign wr_data = cmd.wr_hi ? hi_data : lo_data;
    assign waddr   = cmd.wr_hi ? a1 : a0;
    assign we_a    = cmd.load | ((cmd.wr_lo | cmd.wr_hi) & ~cmd.sel_b);
    assign we_b    = cmd.load | ((cmd.wr_lo | cmd.wr_hi) & cmd.sel_b);
    assign wdata_a = cmd.load ? red_a : wr_data;
    assign wdata_b = cmd.load ? red_b : wr_data;

    always_ff @(posedge clk)
    begin
        if (we_a)
            mem_a_reg[waddr] <= wdata_a;
        if (we_b)
            mem_b_reg[waddr] <= wdata_b;
        if (cmd.rd)
        begin
            ra0_reg <= cmd.zero0 ? '0 : mem_a_reg[a0];
            ra1_reg <= cmd.zero1 ? '0 : mem_a_reg[a1];
            rb0_reg <= cmd.zero0 ? '0 : mem_b_reg[a0];
            rb1_reg <= cmd.zero1 ? '0 : mem_b_reg[a1];
        end
        if (cmd.pre)
        begin
            mx_reg <= mx_next;
            my_reg <= my_next;
            u_reg  <= u_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_reg      <= 1'b0;
            emit_last_reg <= 1'b0;
        end
        else
        begin
            emit_reg      <= cmd.emit;
            emit_last_reg <= cmd.emit & cmd.emit_last;
        end
    end

    assign prod_coef  = ra0_reg;
    assign prod_valid = emit_reg;
    assign last_out   = emit_last_reg;

endmodule

// ===== rtl/npm_ctrl.sv =====
module npm_ctrl
    import npm_pkg::*;
#(
    parameter int CAP = 32
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  logic last,
    output logic busy,
    output cmd_t cmd
);

    localparam int CW = $clog2(CAP + 1);
    localparam logic [CW-1:0] CAP_W = CW'(CAP);

    typedef enum logic [2:0] {S_IDLE, S_RD, S_PRE, S_WAIT, S_WR1, S_WR2, S_EMIT} state_t;
    typedef enum logic [2:0] {PH_FA, PH_FB, PH_PW, PH_INV, PH_SC} phase_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next, n_reg, n_next, n_in;
    logic [2:0] lg_reg, lg_next, e_reg, e_next, wcnt_reg, wcnt_next;
    logic [5:0] k_reg, k_next, half, j, bi, bf_end, full_end;
    logic [6:0] len;
    logic bfly, mask, adv;

    assign len      = 7'd1 << lg_reg;
    assign half     = 6'd1 << (e_reg - 3'd1);
    assign j        = k_reg & (half - 6'd1);
    assign bi       = ((k_reg >> (e_reg - 3'd1)) << e_reg) | j;
    assign bf_end   = 6'(len >> 1) - 6'd1;
    assign full_end = 6'(len - 7'd1);
    assign bfly     = (phase_reg == PH_FA) || (phase_reg == PH_FB) || (phase_reg == PH_INV);
    // first forward stage reads the padding: those words read as zero
    assign mask     = ((phase_reg == PH_FA) || (phase_reg == PH_FB)) && (e_reg == lg_reg);
    assign n_in     = (cnt_reg < CAP_W) ? cnt_reg + CW'(1) : cnt_reg;
    assign busy     = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        n_next     = n_reg;
        lg_next    = lg_reg;
        e_next     = e_reg;
        k_next     = k_reg;
        wcnt_next  = wcnt_reg;
        adv        = 1'b0;

        cmd        = '0;
        cmd.lg     = lg_reg;
        cmd.tw     = 5'(j << (3'd6 - e_reg));
        cmd.addr0  = bfly ? bi : k_reg;
        cmd.addr1  = bi | half;
        cmd.sel_b  = (phase_reg == PH_FB);
        cmd.zero0  = mask && (7'(cmd.addr0) >= 7'(n_reg));
        cmd.zero1  = mask && (7'(cmd.addr1) >= 7'(n_reg));
        case (phase_reg)
            PH_FA, PH_FB: cmd.op = OP_GS;
            PH_INV:       cmd.op = OP_CT;
            PH_PW:        cmd.op = OP_PW;
            default:      cmd.op = OP_SC;
        endcase

        case (state_reg)
            S_IDLE:
            begin
                cmd.addr0 = 6'(cnt_reg);
                cmd.zero0 = 1'b0;
                cmd.zero1 = 1'b0;
                cmd.sel_b = 1'b0;
                if (start)
                begin
                    if (cnt_reg < CAP_W)
                    begin
                        cmd.load = 1'b1;
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (last)
                    begin
                        n_next     = n_in;
                        lg_next    = lg_of(6'(n_in));
                        e_next     = lg_of(6'(n_in));
                        k_next     = '0;
                        phase_next = PH_FA;
                        cnt_next   = '0;
                        state_next = S_RD;
                    end
                end
            end
            S_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = S_PRE;
            end
            S_PRE:
            begin
                cmd.pre    = 1'b1;
                wcnt_next  = '0;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (wcnt_reg == 3'(MONT_LAT - 1))
                    state_next = S_WR1;
                else
                    wcnt_next = wcnt_reg + 3'd1;
            end
            S_WR1:
            begin
                cmd.wr_lo = 1'b1;
                if (bfly)
                    state_next = S_WR2;
                else
                    adv = 1'b1;
            end
            S_WR2:
            begin
                cmd.wr_hi = 1'b1;
                adv       = 1'b1;
            end
            S_EMIT:
            begin
                cmd.addr0     = k_reg;
                cmd.zero0     = 1'b0;
                cmd.zero1     = 1'b0;
                cmd.sel_b     = 1'b0;
                cmd.rd        = 1'b1;
                cmd.emit      = 1'b1;
                cmd.emit_last = ({1'b0, k_reg} == {n_reg, 1'b0} - 7'd1);
                if (cmd.emit_last)
                    state_next = S_IDLE;
                else
                    k_next = k_reg + 6'd1;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (adv)
        begin
            state_next = S_RD;
            k_next     = k_reg + 6'd1;
            case (phase_reg)
                PH_FA, PH_FB:
                begin
                    if (k_reg == bf_end)
                    begin
                        k_next = '0;
                        if (e_reg == 3'd1)
                        begin
                            if (phase_reg == PH_FA)
                            begin
                                phase_next = PH_FB;
                                e_next     = lg_reg;
                            end
                            else
                                phase_next = PH_PW;
                        end
                        else
                            e_next = e_reg - 3'd1;
                    end
                end
                PH_PW:
                begin
                    if (k_reg == full_end)
                    begin
                        k_next     = '0;
                        phase_next = PH_INV;
                        e_next     = 3'd1;
                    end
                end
                PH_INV:
                begin
                    if (k_reg == bf_end)
                    begin
                        k_next = '0;
                        if (e_reg == lg_reg)
                            phase_next = PH_SC;
                        else
                            e_next = e_reg + 3'd1;
                    end
                end
                default:
                begin
                    if (k_reg == full_end)
                    begin
                        k_next     = '0;
                        state_next = S_EMIT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_FA;
            cnt_reg   <= '0;
            n_reg     <= '0;
            lg_reg    <= 3'd1;
            e_reg     <= 3'd1;
            k_reg     <= '0;
            wcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            n_reg     <= n_next;
            lg_reg    <= lg_next;
            e_reg     <= e_next;
            k_reg     <= k_next;
            wcnt_reg  <= wcnt_next;
        end
    end

endmodule

// ===== rtl/ntt_polynomial_multiplier.sv =====
// Channel   Handshake            Ports
// -------   ------------------   -----------------------------------
// input     start & !busy        a_coef[29:0], b_coef[29:0], last
// result    prod_valid strobe    prod_coef[29:0], last_out
//
// A word without last is taken and busy stays low.
// A word with last raises busy; with n pairs the transform length is L = 2^lg >= 2n.
// The single Montgomery multiplier (5-stage pipeline) is used one op at a time.
// Results come 2n words on consecutive cycles; the receiver cannot stall them.
// Reset (rst_n, async, active low) clears control; coefficient memories are
// not cleared, padding reads are forced to zero instead.
module ntt_polynomial_multiplier
    import npm_pkg::*;
#(
    parameter int MAX_TERMS      = 32,
    parameter int TRANSFORM_SIZE = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [29:0] a_coef,
    input  logic [29:0] b_coef,
    input  logic        last,
    output logic [29:0] prod_coef,
    output logic        last_out,
    output logic        prod_valid
);

    // memory depth: largest power of two within TRANSFORM_SIZE and 64
    localparam int DEPTH = max_pow2(TRANSFORM_SIZE);
    // pair capacity; extra pairs are dropped
    localparam int CAP = (MAX_TERMS < DEPTH / 2) ? MAX_TERMS : DEPTH / 2;

    cmd_t cmd;

    // controller: load counter, transform stage/index sequencing, emission
    npm_ctrl #(
        .CAP (CAP)
    ) u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .last  (last),
        .busy  (busy),
        .cmd   (cmd)
    );

    // datapath: two coefficient memories, butterfly operand logic, Montgomery unit
    npm_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .a_coef     (a_coef),
        .b_coef     (b_coef),
        .prod_coef  (prod_coef),
        .last_out   (last_out),
        .prod_valid (prod_valid)
    );

    // results only come out of a run
    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        prod_valid |-> $past(busy))
        else $error("result strobe outside a run");

    a_last_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        last_out |-> prod_valid)
        else $error("last_out without strobe");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        last_out |=> !prod_valid)
        else $error("strobe after final word");

    a_plain_word: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !last) |=> (!prod_valid && !busy))
        else $error("plain word caused activity");

endmodule
